FILE: rtl/smr_pkg.sv
// ---------------------------------------------------------------------------
// smr_pkg
// Shared types and constants for the stereo mixer / sample-rate decimator.
// ---------------------------------------------------------------------------
package smr_pkg;

	// Field widths
	localparam int unsigned TICK_W   = 8;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned VOL_W    = 3;
	localparam int unsigned PAN_W    = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_VAL_W = 8;

	// Default rates
	localparam int unsigned DEF_SAMPLE_RATE = 44100;
	localparam int unsigned DEF_CLOCK_RATE  = 4194304;

	// Pan bit positions
	localparam int unsigned PAN_CH1_LEFT  = 0;
	localparam int unsigned PAN_CH2_LEFT  = 1;
	localparam int unsigned PAN_CH1_RIGHT = 4;
	localparam int unsigned PAN_CH2_RIGHT = 5;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOUND_ON     = 8'd0,
		REG_PAN_BITS     = 8'd1,
		REG_LEFT_VOLUME  = 8'd2,
		REG_RIGHT_VOLUME = 8'd3
	} smr_reg_idx_t;

	// Input item
	typedef struct packed {
		logic        [TICK_W-1:0]  tick_count;
		logic signed [LEVEL_W-1:0] square1_level;
		logic signed [LEVEL_W-1:0] square2_level;
	} smr_levels_t;

	// Result item
	typedef struct packed {
		logic signed [LEVEL_W-1:0] left_sample;
		logic signed [LEVEL_W-1:0] right_sample;
	} smr_samples_t;

	// Register write
	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} smr_cfg_wr_t;

	// Register file contents
	typedef struct packed {
		logic             sound_on;
		logic [PAN_W-1:0] pan_bits;
		logic [VOL_W-1:0] left_volume;
		logic [VOL_W-1:0] right_volume;
	} smr_cfg_regs_t;

endpackage

FILE: rtl/smr_if.sv
// ---------------------------------------------------------------------------
// smr_if
// Valid/ready channels of the mixer: levels in, samples out, register writes.
// ---------------------------------------------------------------------------
interface smr_levels_if
	import smr_pkg::*;
();
	logic        valid;
	logic        ready;
	smr_levels_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface smr_samples_if
	import smr_pkg::*;
();
	logic         valid;
	logic         ready;
	smr_samples_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface smr_cfg_if
	import smr_pkg::*;
();
	logic        valid;
	logic        ready;
	smr_cfg_wr_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/smr_cfg_regs.sv
// ---------------------------------------------------------------------------
// smr_cfg_regs
// Control register file; takes one write transfer per cycle.
// ---------------------------------------------------------------------------
module smr_cfg_regs
	import smr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	smr_cfg_if.sink       cfg,
	output smr_cfg_regs_t regs
);

	smr_cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_SOUND_ON:     regs_q.sound_on     <= cfg.data.value[0];
				REG_PAN_BITS:     regs_q.pan_bits     <= cfg.data.value[PAN_W-1:0];
				REG_LEFT_VOLUME:  regs_q.left_volume  <= cfg.data.value[VOL_W-1:0];
				REG_RIGHT_VOLUME: regs_q.right_volume <= cfg.data.value[VOL_W-1:0];
				default:          ;
			endcase
		end
	end

endmodule

FILE: rtl/smr_tick_lut.sv
// ---------------------------------------------------------------------------
// smr_tick_lut
// Constant table: tick batch times sample rate, reduced modulo clock rate.
// ---------------------------------------------------------------------------
module smr_tick_lut
	import smr_pkg::*;
#(
	parameter int unsigned SAMPLE_RATE = DEF_SAMPLE_RATE,
	parameter int unsigned CLOCK_RATE  = DEF_CLOCK_RATE,
	parameter int unsigned PHASE_W     = $clog2(CLOCK_RATE)
) (
	input  logic [TICK_W-1:0]  tick_count,
	output logic [PHASE_W-1:0] residue,
	output logic               over
);

	localparam int unsigned TableDepth = 1 << TICK_W;

	logic [PHASE_W-1:0] res_tab  [TableDepth];
	logic               over_tab [TableDepth];

	// One entry per tick count, all folded at elaboration
	for (genvar g = 0; g < TableDepth; g++) begin : g_entry
		localparam int unsigned Prod = g * SAMPLE_RATE;
		localparam int unsigned Res  = Prod % CLOCK_RATE;
		assign res_tab[g]  = PHASE_W'(Res);
		assign over_tab[g] = (Prod >= CLOCK_RATE);
	end

	assign residue = res_tab[tick_count];
	assign over    = over_tab[tick_count];

endmodule

FILE: rtl/smr_mix_side.sv
// ---------------------------------------------------------------------------
// smr_mix_side
// One side of the mixer: panned sum, volume scale, divide by eight.
// ---------------------------------------------------------------------------
module smr_mix_side
	import smr_pkg::*;
(
	input  logic signed [LEVEL_W-1:0] ch1,
	input  logic signed [LEVEL_W-1:0] ch2,
	input  logic                      use_ch1,
	input  logic                      use_ch2,
	input  logic        [VOL_W-1:0]   volume,
	output logic signed [LEVEL_W-1:0] sample
);

	localparam int unsigned ProdW = LEVEL_W + VOL_W + 1;

	logic signed [LEVEL_W-1:0] sum;
	logic signed [ProdW-1:0]   prod;
	logic signed [ProdW-1:0]   biased;
	logic signed [ProdW-1:0]   quot;

	always_comb begin
		// Sum wraps within the level width
		sum    = (use_ch1 ? ch1 : '0) + (use_ch2 ? ch2 : '0);
		prod   = sum * $signed({1'b0, volume});
		// Bias negatives so the shift truncates toward zero
		biased = prod + (prod[ProdW-1] ? ProdW'(7) : ProdW'(0));
		quot   = biased >>> VOL_W;
		sample = quot[LEVEL_W-1:0];
	end

endmodule

FILE: rtl/stereo_mixer_resampler_core.sv
// ---------------------------------------------------------------------------
// stereo_mixer_resampler_core
// Two-channel stereo mixer with CPU-clock to sample-rate decimation.
// ---------------------------------------------------------------------------
// Usage:
//   levels  - sink; each transfer gives a tick count and both channel levels.
//   samples - source; one stereo pair whenever the phase accumulator crosses
//             a sample boundary, at most one pair per levels transfer.
//   cfg     - sink; register writes, always ready, applied in the next cycle.
//             Write only while no item is in flight.
// Pipeline: a levels item is registered in the input stage, and its pair
//   in the output register, which drives samples.
// Throughput: one levels transfer per cycle unless output stalls; the phase
//   update is a single add and compare against CLOCK_RATE, fed by a 256-entry
//   constant table that reduces tick_count * SAMPLE_RATE in the input stage.
// Reset: arst_n clears the phase, the registers and both pipeline valid flags.
// Stall: a pending pair is held in the output register; the input stage
//   keeps accepting until it fills, then levels.ready drops with
//   samples.ready.
// ---------------------------------------------------------------------------
module stereo_mixer_resampler_core
	import smr_pkg::*;
#(
	parameter int unsigned SAMPLE_RATE = DEF_SAMPLE_RATE,
	parameter int unsigned CLOCK_RATE  = DEF_CLOCK_RATE
) (
	input  logic          clk,
	input  logic          arst_n,
	smr_levels_if.sink    levels,
	smr_samples_if.source samples,
	smr_cfg_if.sink       cfg
);

	localparam int unsigned PhaseW = $clog2(CLOCK_RATE);
	localparam logic [PhaseW:0] ClockMod = (PhaseW + 1)'(CLOCK_RATE);

	smr_cfg_regs_t cfg_regs;

	logic [PhaseW-1:0] lut_residue;
	logic              lut_over;

	logic                      valid_s1;
	logic [PhaseW-1:0]         residue_s1;
	logic                      over_s1;
	logic signed [LEVEL_W-1:0] sq1_s1;
	logic signed [LEVEL_W-1:0] sq2_s1;

	logic [PhaseW-1:0] phase_q;
	logic [PhaseW:0]   phase_sum;
	logic              phase_wrap;
	logic [PhaseW-1:0] phase_next;
	logic              crossed;

	logic signed [LEVEL_W-1:0] left_mix;
	logic signed [LEVEL_W-1:0] right_mix;

	logic         pair_valid_q;
	smr_samples_t pair_q;

	logic advance;
	logic take_in;

	smr_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	smr_tick_lut #(
		.SAMPLE_RATE (SAMPLE_RATE),
		.CLOCK_RATE  (CLOCK_RATE),
		.PHASE_W     (PhaseW)
	) u_tick_lut (
		.tick_count (levels.data.tick_count),
		.residue    (lut_residue),
		.over       (lut_over)
	);

	// Handshake: output register frees when empty or taken
	assign advance      = !pair_valid_q || samples.ready;
	assign levels.ready = !valid_s1 || advance;
	assign take_in      = levels.valid && levels.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (levels.ready) begin
			valid_s1 <= levels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			residue_s1 <= lut_residue;
			over_s1    <= lut_over;
			sq1_s1     <= levels.data.square1_level;
			sq2_s1     <= levels.data.square2_level;
		end
	end

	// Phase accumulator: one add, one conditional subtract
	always_comb begin
		phase_sum  = {1'b0, phase_q} + {1'b0, residue_s1};
		phase_wrap = (phase_sum >= ClockMod);
		phase_next = phase_wrap ? PhaseW'(phase_sum - ClockMod) : phase_sum[PhaseW-1:0];
		crossed    = over_s1 || phase_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_next;
		end
	end

	// Mixing, one instance per side
	smr_mix_side u_mix_left (
		.ch1     (sq1_s1),
		.ch2     (sq2_s1),
		.use_ch1 (cfg_regs.pan_bits[PAN_CH1_LEFT]),
		.use_ch2 (cfg_regs.pan_bits[PAN_CH2_LEFT]),
		.volume  (cfg_regs.left_volume),
		.sample  (left_mix)
	);

	smr_mix_side u_mix_right (
		.ch1     (sq1_s1),
		.ch2     (sq2_s1),
		.use_ch1 (cfg_regs.pan_bits[PAN_CH1_RIGHT]),
		.use_ch2 (cfg_regs.pan_bits[PAN_CH2_RIGHT]),
		.volume  (cfg_regs.right_volume),
		.sample  (right_mix)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
		end else if (advance) begin
			pair_valid_q <= valid_s1 && crossed;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && crossed) begin
			pair_q.left_sample  <= cfg_regs.sound_on ? left_mix  : '0;
			pair_q.right_sample <= cfg_regs.sound_on ? right_mix : '0;
		end
	end

	assign samples.valid = pair_valid_q;
	assign samples.data  = pair_q;

	// Checks
	a_phase_below_mod : assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < ClockMod[PhaseW-1:0] || ClockMod[PhaseW])
		else $error("phase accumulator reached the clock rate");

	a_phase_holds_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(phase_q))
		else $error("phase moved while the output stage was stalled");

	a_pair_needs_item : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pair_valid_q) |-> $past(valid_s1))
		else $error("pair produced without an item in the input stage");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for stereo_mixer_resampler_core. Level items are
// queued by the stimulus process, offered by a falling-edge driver and
// predicted on transfer. Every sample pair is checked against the oldest
// predicted pair. The run walks through several register settings and
// handshake idling patterns, including a long output hold-off.
// ---------------------------------------------------------------------------
module tb
	import smr_pkg::*;
();

	localparam int          CLK_PERIOD     = 10;
	localparam int          RESET_CYCLES   = 11;
	localparam int          PIPE_LATENCY   = 2;
	localparam int          DRAIN_LIMIT    = 2000;
	localparam int          PHASE_ITEMS    = 225;
	localparam int          LONG_HOLD      = 300;
	localparam int          MAX_REPORTS    = 10;
	localparam longint      TIMEOUT_NS     = 64'd5_000_000;
	localparam int unsigned NUM_REGS       = REG_RIGHT_VOLUME + 1;
	localparam longint unsigned SAMPLE_HZ  = DEF_SAMPLE_RATE;
	localparam longint unsigned CLOCK_HZ   = DEF_CLOCK_RATE;

	logic clk = 1'b0;
	logic arst_n;

	smr_levels_if  levels_ch ();
	smr_samples_if samples_ch ();
	smr_cfg_if     cfg_ch ();

	stereo_mixer_resampler_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.levels  (levels_ch),
		.samples (samples_ch),
		.cfg     (cfg_ch)
	);

	// Clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus and scoreboard state
	smr_levels_t  level_q[$];
	smr_samples_t pair_q[$];
	bit           lv_offered = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_ask = 0;
	int           hold_left = 0;
	int           err_cnt = 0;
	int           n_levels = 0;
	int           n_pairs = 0;
	int           n_writes = 0;
	int           n_settings = 0;

	// Predictor copy of the block state and registers
	longint unsigned  phase_acc = 0;
	bit               r_sound_on = 1'b0;
	logic [PAN_W-1:0] r_pan = '0;
	logic [VOL_W-1:0] r_left_vol = '0;
	logic [VOL_W-1:0] r_right_vol = '0;

	task automatic flag(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	// One side of the mix: 16-bit wrapped sum, times volume, eighths toward zero
	function automatic logic signed [LEVEL_W-1:0] mix_channel(
		input logic signed [LEVEL_W-1:0] a,
		input logic signed [LEVEL_W-1:0] b,
		input bit use_a,
		input bit use_b,
		input logic [VOL_W-1:0] vol
	);
		logic [LEVEL_W-1:0] acc;
		int scaled;
		acc = '0;
		if (use_a) acc = acc + a;
		if (use_b) acc = acc + b;
		scaled = (int'($signed(acc)) * int'(vol)) / 8;
		return scaled[LEVEL_W-1:0];
	endfunction

	// Advance the phase and queue a pair when a sample boundary is crossed
	task automatic predict_levels(input smr_levels_t it);
		longint unsigned next_phase;
		smr_samples_t pair;
		next_phase = phase_acc + longint'(it.tick_count) * SAMPLE_HZ;
		phase_acc = next_phase % CLOCK_HZ;
		if (next_phase >= CLOCK_HZ) begin
			pair = '0;
			if (r_sound_on) begin
				pair.left_sample = mix_channel(it.square1_level, it.square2_level,
					r_pan[PAN_CH1_LEFT], r_pan[PAN_CH2_LEFT], r_left_vol);
				pair.right_sample = mix_channel(it.square1_level, it.square2_level,
					r_pan[PAN_CH1_RIGHT], r_pan[PAN_CH2_RIGHT], r_right_vol);
			end
			pair_q.push_back(pair);
		end
	endtask

	// Level driver: holds an offered item until its transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			levels_ch.valid <= 1'b0;
		end else if (!lv_offered) begin
			if (level_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				levels_ch.data  <= level_q.pop_front();
				levels_ch.valid <= 1'b1;
				lv_offered = 1'b1;
			end else begin
				levels_ch.valid <= 1'b0;
			end
		end
	end

	// Sample ready driver, with its own count for long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			samples_ch.ready <= 1'b0;
		end else if (hold_ask != 0) begin
			hold_left = hold_ask - 1;
			hold_ask = 0;
			samples_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			samples_ch.ready <= 1'b0;
		end else begin
			samples_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: register writes, level transfers and pair checks
	always @(posedge clk) begin
		smr_samples_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				n_writes++;
				case (cfg_ch.data.index)
					REG_SOUND_ON:     r_sound_on  = cfg_ch.data.value[0];
					REG_PAN_BITS:     r_pan       = cfg_ch.data.value[PAN_W-1:0];
					REG_LEFT_VOLUME:  r_left_vol  = cfg_ch.data.value[VOL_W-1:0];
					REG_RIGHT_VOLUME: r_right_vol = cfg_ch.data.value[VOL_W-1:0];
					default: ;
				endcase
			end
			if (levels_ch.valid && levels_ch.ready) begin
				lv_offered = 1'b0;
				n_levels++;
				predict_levels(levels_ch.data);
			end
			if (samples_ch.valid && samples_ch.ready) begin
				n_pairs++;
				if (pair_q.size() == 0) begin
					flag($sformatf("unexpected pair left %0d right %0d",
						samples_ch.data.left_sample, samples_ch.data.right_sample));
				end else begin
					want = pair_q.pop_front();
					if (samples_ch.data.left_sample !== want.left_sample)
						flag($sformatf("pair %0d left: expected %0d, got %0d", n_pairs,
							want.left_sample, samples_ch.data.left_sample));
					if (samples_ch.data.right_sample !== want.right_sample)
						flag($sformatf("pair %0d right: expected %0d, got %0d", n_pairs,
							want.right_sample, samples_ch.data.right_sample));
				end
			end
		end
	end

	// Stimulus helpers
	task automatic push_levels(input int ticks, input int lvl1, input int lvl2);
		smr_levels_t it;
		it.tick_count    = ticks[TICK_W-1:0];
		it.square1_level = lvl1[LEVEL_W-1:0];
		it.square2_level = lvl2[LEVEL_W-1:0];
		level_q.push_back(it);
	endtask

	function automatic int random_ticks();
		int k;
		k = $urandom_range(99);
		if (k < 10) return 0;
		if (k < 25) return $urandom_range(8);
		if (k < 40) return $urandom_range(100, 90);
		if (k < 45) return 255;
		return $urandom_range(255);
	endfunction

	function automatic int pick_level();
		if ($urandom_range(99) < 30) begin
			case ($urandom_range(4))
				0: return 32767;
				1: return -32768;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		return $urandom_range(65535);
	endfunction

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] val);
		@(negedge clk);
		cfg_ch.data  <= '{index: idx, value: val};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// All four registers plus one write to an unused index, with junk upper bits
	task automatic set_regs(input bit on, input logic [PAN_W-1:0] pan,
			input logic [VOL_W-1:0] lv, input logic [VOL_W-1:0] rv);
		reg_write(REG_SOUND_ON, {7'($urandom), on});
		reg_write(REG_PAN_BITS, pan);
		reg_write(REG_LEFT_VOLUME, {5'($urandom), lv});
		reg_write(REG_RIGHT_VOLUME, {5'($urandom), rv});
		reg_write(CFG_IDX_W'($urandom_range(255, NUM_REGS)), CFG_VAL_W'($urandom));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		n_settings++;
	endtask

	// Wait for the sender to empty, then for every predicted pair
	task automatic drain();
		int waited;
		while (level_q.size() != 0 || lv_offered) @(posedge clk);
		waited = 0;
		while (pair_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic run_phase(input bit on, input logic [PAN_W-1:0] pan,
			input logic [VOL_W-1:0] lv, input logic [VOL_W-1:0] rv,
			input int send_pct, input int recv_pct, input int hold_len, input bit split);
		set_regs(on, pan, lv, rv);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// sender pauses here until every pair so far has come out
			if (split && i == PHASE_ITEMS / 2)
				drain();
			push_levels(random_ticks(), pick_level(), pick_level());
		end
		if (hold_len != 0) begin
			@(posedge clk);
			hold_ask = hold_len;
		end
		drain();
	endtask

	// Drive every input to a known value from the start
	initial begin
		arst_n           = 1'b0;
		levels_ch.valid  = 1'b0;
		levels_ch.data   = '0;
		samples_ch.ready = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
	end

	// Main sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: sound off, pairs come out zero
		push_levels(0, 32767, 32767);
		push_levels(255, 32767, -32768);
		push_levels(255, -1, 1);
		push_levels(96, 1000, 2000);
		drain();

		// Full volume, both channels on both sides
		set_regs(1'b1, 8'h33, 3'd7, 3'd7);
		push_levels(0, 32767, 32767);
		push_levels(255, 32767, 32767);
		push_levels(255, -32768, -32768);
		push_levels(255, 32767, 0);
		push_levels(255, -32768, 0);
		push_levels(255, -1, 0);
		push_levels(255, 1, 0);
		push_levels(255, 0, 0);
		push_levels(1, 12345, -12345);
		push_levels(1, 32767, -1);
		push_levels(95, -32768, 32767);
		push_levels(96, -20000, -20000);
		push_levels(0, -32768, -32768);
		push_levels(255, 16384, 16384);
		push_levels(255, -16385, -16384);
		push_levels(100, 7, -8);
		drain();

		// Settings sweep with the idling patterns
		run_phase(1'b1, 8'hFF, 3'd7, 3'd7,  0,  0, 0, 1'b0);
		run_phase(1'b1, 8'h33, 3'd0, 3'd7, 50,  0, 0, 1'b0);
		run_phase(1'b0, PAN_W'($urandom), VOL_W'($urandom), VOL_W'($urandom),
			0, 50, LONG_HOLD, 1'b0);
		run_phase(1'b1, 8'hCC, 3'd7, 3'd7, 20, 20, 0, 1'b0);
		run_phase(1'b1, PAN_W'($urandom), VOL_W'($urandom), VOL_W'($urandom),
			0, 0, 0, 1'b1);
		run_phase(1'b1, PAN_W'($urandom), VOL_W'($urandom), VOL_W'($urandom),
			50, 0, 0, 1'b0);
		run_phase(1'b1, PAN_W'($urandom), VOL_W'($urandom), VOL_W'($urandom),
			0, 50, 0, 1'b0);
		run_phase(1'b1, 8'h00, 3'd7, 3'd7, 20, 20, 0, 1'b0);

		if (pair_q.size() != 0)
			flag($sformatf("%0d predicted pairs never came out", pair_q.size()));
		$display("tb: %0d level transfers, %0d sample pairs, %0d register writes",
			n_levels, n_pairs, n_writes);
		$display("tb: %0d register settings, idle and stall patterns, %0d-cycle hold-off",
			n_settings, LONG_HOLD);
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches", err_cnt);
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("tb: timeout at %0t", $time);
		$display("tb: failure");
		$finish;
	end

endmodule
